[hdl/mspp_pkg.sv]
// Shared types and constants for the motor speed PID/PWM controller.
package mspp_pkg;

    // Internal arithmetic width: holds any sum of two signed 64-bit values.
    localparam int WIDE    = 66;
    // Multiplier operand widths and product width.
    localparam int MAG_W   = 33;
    localparam int MB_W    = 16;
    localparam int PROD_W  = MAG_W + MB_W;
    // Divide-by-1000 unit: dividend width and remainder width.
    localparam int DIV_W   = 63;
    localparam int REM_W   = 10;
    localparam int MS_PER_SECOND = 1000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP     = 3'd5;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_ADD_S64,
        ALU_SUB_S64,
        ALU_ADD_SACC,
        ALU_SUB_SACC,
        ALU_CLAMP
    } alu_op_t;

    typedef struct packed {
        alu_op_t                 op;
        logic signed [WIDE-1:0]  a;
        logic signed [WIDE-1:0]  b;
        logic [MAG_W-1:0]        ma;
        logic [MB_W-1:0]         mb;
    } alu_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERR,
        ST_EMAG,
        ST_DIFF,
        ST_DMAG,
        ST_KD,
        ST_KI,
        ST_PMUL,
        ST_PADD,
        ST_DLO,
        ST_DHI,
        ST_DSUM,
        ST_DADD,
        ST_ILO,
        ST_IHI,
        ST_ISUM,
        ST_DIVGO,
        ST_DIV,
        ST_IACC,
        ST_IADD,
        ST_CLAMP
    } seq_state_t;

endpackage

[hdl/mspp_ifs.sv]
// Channel interfaces of the motor speed PID/PWM controller.
interface mspp_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pulse_count;
    logic [15:0]        target_speed;

    modport source (output valid, output pulse_count, output target_speed, input ready);
    modport sink   (input valid, input pulse_count, input target_speed, output ready);
endinterface

interface mspp_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        duty;
    logic signed [31:0] measured_speed;
    logic signed [31:0] speed_error;

    modport source (output valid, output duty, output measured_speed, output speed_error,
                    input ready);
    modport sink   (input valid, input duty, input measured_speed, input speed_error,
                    output ready);
endinterface

interface mspp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/motor_speed_pid_pwm.sv]
// Top level of the motor speed PID controller with PWM duty output.
//
//  Channel  Role    Payload                                   Transaction when
//  -------  ------  ----------------------------------------  ---------------------
//  sample   sink    pulse_count (s32), target_speed (u16)     valid && ready
//  result   source  duty (u16), measured_speed, speed_error   valid && ready
//  cfg      sink    index (3 bits), data (u16)                valid && ready
//
// A sample passes from its transaction to a valid result through 16 steps of the
// shared arithmetic unit, one divider start, four digit steps of the divide by 1000
// and its done flag, and three more unit steps for the integrator, the final sum and
// the duty clamp. The sample channel is ready only while the sequencer is idle, so a
// new sample is accepted only once the previous one has left the clamp step. The
// result register lets the sequencer go idle while a result waits; a stalled result
// holds the sequencer in its clamp step until taken.
// Reset is asynchronous and active low and restores the register defaults and the
// controller history (count, error, integral, duty) to zero.
module motor_speed_pid_pwm
    import mspp_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    mspp_sample_if.sink     sample,
    mspp_result_if.source   result,
    mspp_cfg_if.sink        cfg
);

    // Configuration registers.
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [15:0] sample_ms_reg;
    logic [15:0] inv_period_reg;
    logic [15:0] pwm_top_reg;

    // Controller history, kept from one sample to the next.
    logic signed [31:0]          last_count_reg;
    logic signed [31:0]          last_error_reg;
    logic signed [ACC_WIDTH-1:0] integ_reg;
    logic [15:0]                 duty_reg;

    // Working registers of the current sample.
    logic signed [31:0] count_reg;
    logic [15:0]        target_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] err_reg;
    logic [31:0]        emag_reg;
    logic signed [32:0] diff_reg;
    logic [32:0]        dmag_reg;
    logic [31:0]        kd_reg;
    logic [31:0]        ki_reg;
    logic [63:0]        prod_reg;
    logic [PROD_W-1:0]  hi_reg;
    logic signed [63:0] sum_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_duty_reg;
    logic signed [31:0] out_speed_reg;
    logic signed [31:0] out_err_reg;

    seq_state_t state_reg, state_next;

    alu_req_t               alu_req;
    logic signed [WIDE-1:0] alu_res;

    logic             div_start;
    logic [DIV_W-1:0] div_quo;
    logic             div_busy;
    logic             div_done;
    logic             commit;

    function automatic logic signed [WIDE-1:0] sx32(input logic signed [31:0] v);
        return {{(WIDE-32){v[31]}}, v};
    endfunction

    mspp_alu #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    mspp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[DIV_W-1:0]),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    // The clamp step may finish only when the result register is free.
    assign commit = (state_reg == ST_CLAMP) && (!out_valid_reg || result.ready);

    // Sequencer: next state and the operands of the shared unit.
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        alu_req.op   = ALU_ADD;
        alu_req.a    = '0;
        alu_req.b    = '0;
        alu_req.ma   = '0;
        alu_req.mb   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                    state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = sx32(count_reg);
                alu_req.b  = sx32(last_count_reg);
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                // Target minus magnitude: a negative speed is simply added.
                alu_req.op = speed_reg[31] ? ALU_ADD : ALU_SUB;
                alu_req.a  = {{(WIDE-16){1'b0}}, target_reg};
                alu_req.b  = sx32(speed_reg);
                state_next = ST_EMAG;
            end
            ST_EMAG:
            begin
                alu_req.op = err_reg[31] ? ALU_SUB : ALU_ADD;
                alu_req.b  = sx32(err_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = sx32(err_reg);
                alu_req.b  = sx32(last_error_reg);
                state_next = ST_DMAG;
            end
            ST_DMAG:
            begin
                alu_req.op = diff_reg[32] ? ALU_SUB : ALU_ADD;
                alu_req.b  = {{(WIDE-33){diff_reg[32]}}, diff_reg};
                state_next = ST_KD;
            end
            ST_KD:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = {{(MAG_W-16){1'b0}}, deriv_gain_reg};
                alu_req.mb = inv_period_reg;
                state_next = ST_KI;
            end
            ST_KI:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = {{(MAG_W-16){1'b0}}, integ_gain_reg};
                alu_req.mb = sample_ms_reg;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = {1'b0, emag_reg};
                alu_req.mb = prop_gain_reg;
                state_next = ST_PADD;
            end
            ST_PADD:
            begin
                alu_req.op = err_reg[31] ? ALU_SUB_S64 : ALU_ADD_S64;
                alu_req.a  = {{(WIDE-16){1'b0}}, duty_reg};
                alu_req.b  = {{(WIDE-64){1'b0}}, prod_reg};
                state_next = ST_DLO;
            end
            ST_DLO:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = dmag_reg;
                alu_req.mb = kd_reg[15:0];
                state_next = ST_DHI;
            end
            ST_DHI:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = dmag_reg;
                alu_req.mb = kd_reg[31:16];
                state_next = ST_DSUM;
            end
            ST_DSUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {{(WIDE-64){1'b0}}, prod_reg};
                alu_req.b  = {{(WIDE-PROD_W-16){1'b0}}, hi_reg, 16'h0000};
                state_next = ST_DADD;
            end
            ST_DADD:
            begin
                alu_req.op = diff_reg[32] ? ALU_SUB_S64 : ALU_ADD_S64;
                alu_req.a  = {{(WIDE-64){sum_reg[63]}}, sum_reg};
                alu_req.b  = {{(WIDE-64){1'b0}}, prod_reg};
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = {1'b0, emag_reg};
                alu_req.mb = ki_reg[15:0];
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                alu_req.op = ALU_MUL;
                alu_req.ma = {1'b0, emag_reg};
                alu_req.mb = ki_reg[31:16];
                state_next = ST_ISUM;
            end
            ST_ISUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {{(WIDE-64){1'b0}}, prod_reg};
                alu_req.b  = {{(WIDE-PROD_W-16){1'b0}}, hi_reg, 16'h0000};
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_IACC;
            end
            ST_IACC:
            begin
                // The quotient of the magnitude gives truncation toward zero.
                alu_req.op = err_reg[31] ? ALU_SUB_SACC : ALU_ADD_SACC;
                alu_req.a  = {{(WIDE-ACC_WIDTH){integ_reg[ACC_WIDTH-1]}}, integ_reg};
                alu_req.b  = {{(WIDE-DIV_W){1'b0}}, div_quo};
                state_next = ST_IADD;
            end
            ST_IADD:
            begin
                alu_req.op = ALU_ADD_S64;
                alu_req.a  = {{(WIDE-64){sum_reg[63]}}, sum_reg};
                alu_req.b  = {{(WIDE-ACC_WIDTH){integ_reg[ACC_WIDTH-1]}}, integ_reg};
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                alu_req.op = ALU_CLAMP;
                alu_req.a  = {{(WIDE-64){sum_reg[63]}}, sum_reg};
                alu_req.b  = {{(WIDE-16){1'b0}}, pwm_top_reg};
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state, configuration and controller history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prop_gain_reg  <= 16'd1;
            integ_gain_reg <= 16'd0;
            deriv_gain_reg <= 16'd0;
            sample_ms_reg  <= 16'd25;
            inv_period_reg <= 16'd40;
            pwm_top_reg    <= 16'd256;
            last_count_reg <= '0;
            last_error_reg <= '0;
            integ_reg      <= '0;
            duty_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg.data;
                    REG_INTEG_GAIN: integ_gain_reg <= cfg.data;
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg.data;
                    REG_SAMPLE_MS:  sample_ms_reg  <= cfg.data;
                    REG_INV_PERIOD: inv_period_reg <= cfg.data;
                    REG_PWM_TOP:    pwm_top_reg    <= cfg.data;
                    default:        ;
                endcase
            end
            if (state_reg == ST_IACC)
                integ_reg <= alu_res[ACC_WIDTH-1:0];
            if (commit)
            begin
                duty_reg       <= alu_res[15:0];
                last_count_reg <= count_reg;
                last_error_reg <= err_reg;
            end
        end
    end

    // Working registers of the current sample and the result payload.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    count_reg  <= sample.pulse_count;
                    target_reg <= sample.target_speed;
                end
            end
            ST_SPEED: speed_reg <= alu_res[31:0];
            ST_ERR:   err_reg   <= alu_res[31:0];
            ST_EMAG:  emag_reg  <= alu_res[31:0];
            ST_DIFF:  diff_reg  <= alu_res[32:0];
            ST_DMAG:  dmag_reg  <= alu_res[32:0];
            ST_KD:    kd_reg    <= alu_res[31:0];
            ST_KI:    ki_reg    <= alu_res[31:0];
            ST_PMUL:  prod_reg  <= alu_res[63:0];
            ST_PADD:  sum_reg   <= alu_res[63:0];
            ST_DLO:   prod_reg  <= alu_res[63:0];
            ST_DHI:   hi_reg    <= alu_res[PROD_W-1:0];
            ST_DSUM:  prod_reg  <= alu_res[63:0];
            ST_DADD:  sum_reg   <= alu_res[63:0];
            ST_ILO:   prod_reg  <= alu_res[63:0];
            ST_IHI:   hi_reg    <= alu_res[PROD_W-1:0];
            ST_ISUM:  prod_reg  <= alu_res[63:0];
            ST_IADD:  sum_reg   <= alu_res[63:0];
            ST_CLAMP:
            begin
                if (commit)
                begin
                    out_duty_reg  <= alu_res[15:0];
                    out_speed_reg <= speed_reg;
                    out_err_reg   <= err_reg;
                end
            end
            default: ;
        endcase
    end

    assign sample.ready          = (state_reg == ST_IDLE);
    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.duty           = out_duty_reg;
    assign result.measured_speed = out_speed_reg;
    assign result.speed_error    = out_err_reg;

    // A sample transaction always starts the speed step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == ST_SPEED)
        else $error("sample transaction did not start the sequencer");

    // The divider runs only while the sequencer waits for it.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DIV |-> !div_busy)
        else $error("divider busy outside its wait step");

    // A pending result is never overwritten: the clamp step waits for it.
    a_clamp_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLAMP && result.valid && !result.ready |=> state_reg == ST_CLAMP)
        else $error("clamp step left while the result register was full");

    // Delivered duty lies inside the PWM period.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.duty >= 16'd1 &&
                         (pwm_top_reg < 16'd2 || result.duty < pwm_top_reg))
        else $error("duty outside 1 to top minus one");

endmodule

[hdl/mspp_alu.sv]
// Shared arithmetic unit: add, subtract, multiply, saturate and duty clamp.
module mspp_alu
    import mspp_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  alu_req_t               req,
    output logic signed [WIDE-1:0] res
);

    localparam logic signed [WIDE-1:0] S64_MAX = {{(WIDE-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [WIDE-1:0] S64_MIN = {{(WIDE-63){1'b1}}, {63{1'b0}}};
    localparam logic signed [WIDE-1:0] ACC_MAX =
        {{(WIDE-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE-1:0] ACC_MIN =
        {{(WIDE-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE-1:0] ONE  = WIDE'(1);
    localparam logic signed [WIDE-1:0] ZERO = '0;

    logic signed [WIDE-1:0] sum;
    logic signed [WIDE-1:0] dif;
    logic signed [WIDE-1:0] top_m1;
    logic [PROD_W-1:0]      prod;

    function automatic logic signed [WIDE-1:0] sat_range(
        input logic signed [WIDE-1:0] v,
        input logic signed [WIDE-1:0] hi,
        input logic signed [WIDE-1:0] lo
    );
        logic signed [WIDE-1:0] r;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r;
    endfunction

    assign sum    = req.a + req.b;
    assign dif    = req.a - req.b;
    assign top_m1 = req.b - ONE;
    assign prod   = {{MB_W{1'b0}}, req.ma} * {{MAG_W{1'b0}}, req.mb};

    always_comb
    begin
        unique case (req.op)
            ALU_ADD:      res = sum;
            ALU_SUB:      res = dif;
            ALU_MUL:      res = $signed({{(WIDE-PROD_W){1'b0}}, prod});
            ALU_ADD_S64:  res = sat_range(sum, S64_MAX, S64_MIN);
            ALU_SUB_S64:  res = sat_range(dif, S64_MAX, S64_MIN);
            ALU_ADD_SACC: res = sat_range(sum, ACC_MAX, ACC_MIN);
            ALU_SUB_SACC: res = sat_range(dif, ACC_MAX, ACC_MIN);
            ALU_CLAMP:
            begin
                // Upper limit first, then the lower one.
                if (req.a >= req.b)
                    res = (req.b <= ONE) ? ONE : top_m1;
                else
                    res = (req.a <= ZERO) ? ONE : req.a;
            end
            default:      res = sum;
        endcase
    end

endmodule

[hdl/mspp_div.sv]
// Divider by the constant 1000: long division in 16-bit digits, one digit per cycle.
module mspp_div
    import mspp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    output logic [DIV_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    // The dividend is taken in four 16-bit digits, most significant first. Each partial
    // dividend is the running remainder (below 1000) joined with the next digit, so it
    // stays below 2^26. Its product with ceil(2^36 / 1000), shifted down by 36, is then
    // the exact quotient digit, and the new remainder is what is left after that digit.
    localparam int DIG_W  = 16;
    localparam int NDIG   = 4;
    localparam int QUO_W  = DIG_W * NDIG;
    localparam int PART_W = REM_W + DIG_W;
    localparam int RCP_W  = 27;
    localparam int RCP_SH = 36;
    localparam int EST_W  = PART_W + RCP_W;
    localparam int CNT_W  = 3;
    localparam logic [RCP_W-1:0] RCP_K =
        RCP_W'(((64'd1 << RCP_SH) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));
    localparam logic [REM_W-1:0] DIV_K    = REM_W'(MS_PER_SECOND);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NDIG);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PART_W-1:0] part;
    logic [EST_W-1:0]  est;
    logic [DIG_W-1:0]  qdig;
    logic [PART_W-1:0] qdig_k;
    logic [PART_W-1:0] part_rem;

    assign part     = {rem_reg, quo_reg[QUO_W-1 -: DIG_W]};
    assign est      = {{RCP_W{1'b0}}, part} * {{PART_W{1'b0}}, RCP_K};
    assign qdig     = est[RCP_SH +: DIG_W];
    assign qdig_k   = {{REM_W{1'b0}}, qdig} * {{DIG_W{1'b0}}, DIV_K};
    assign part_rem = part - qdig_k;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = {{(QUO_W-DIV_W){1'b0}}, dividend};
            rem_next  = '0;
            cnt_next  = CNT_FULL;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = part_rem[REM_W-1:0];
            quo_next = {quo_reg[QUO_W-DIG_W-1:0], qdig};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg[DIV_W-1:0];
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule
